@@ rtl/core/median_step_spike_detector_core_defines.svh @@
// Assertion macros for the median step spike detector checker.
// Needs signals named clock and reset in the scope of each use.
`ifndef MEDIAN_STEP_SPIKE_DETECTOR_CORE_DEFINES_SVH
`define MEDIAN_STEP_SPIKE_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define MSSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mssd_pkg.sv @@
// Shared types and constants of the median step spike detector.
// No dependencies; used by every module of the block.
package mssd_pkg;

   localparam int SPEED_W   = 16;
   localparam int CH_W      = 3;
   localparam int COUNT_W   = 8;
   localparam int CSR_W     = 16;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_STEP_THR    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_RANGE_THR   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_REQ_STRIKES = 2'd2;

   localparam logic [SPEED_W-1:0] STEP_THR_RST    = 16'd300;
   localparam logic [SPEED_W-1:0] RANGE_THR_RST   = 16'd300;
   localparam logic [COUNT_W-1:0] REQ_STRIKES_RST = 8'd3;

   localparam int MIN_FILL = 5;
   localparam logic [COUNT_W-1:0] STRIKE_MAX = 8'hFF;

   // result word layout, lowest bit first
   localparam int ALARM_BIT = 0;
   localparam int SUSP_BIT  = 1;
   localparam int CNT_LSB   = 2;
   localparam int MED_LSB   = CNT_LSB + COUNT_W;
   localparam int RSP_W     = 32;
   localparam int RSP_PAD_W = RSP_W - (MED_LSB + SPEED_W);

   typedef struct packed {
      logic start;
      logic read;
      logic eval;
      logic calc;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic last_idx;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/mssd_ctrl.sv @@
// Sequencer of the median step spike detector.
// Depends on mssd_pkg; drives the datapath through cmd_type / status_type.
module mssd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mssd_pkg::status_type status,
   output mssd_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_CALC  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.bypass) begin
               state_in = ST_EVAL;
            end else begin
               cmd.read = 1'b1;
               if (status.last_idx) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/mssd_dpath.sv @@
// Datapath: sample memory, per-channel state, sorting window, decision logic.
// Depends on mssd_pkg; commanded by mssd_ctrl.
module mssd_dpath #(
   parameter int CHANNELS = 8,
   parameter int WINDOW   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mssd_pkg::cmd_type               cmd,
   output mssd_pkg::status_type            status,
   input  logic [mssd_pkg::CH_W-1:0]       req_ch,
   input  logic [mssd_pkg::SPEED_W-1:0]    req_speed,
   input  logic                            csr_we,
   input  logic [mssd_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mssd_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [mssd_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int CI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW   = $clog2(WINDOW);
   localparam int FW   = $clog2(WINDOW + 1);
   localparam int AW   = $clog2(CHANNELS * WINDOW);
   localparam int SW   = mssd_pkg::SPEED_W;
   localparam int KW   = mssd_pkg::COUNT_W;

   localparam logic [PW-1:0] LAST_POS  = PW'(WINDOW - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(WINDOW);
   localparam logic [FW-1:0] MIN_FILLV = FW'(mssd_pkg::MIN_FILL);

   // configuration
   logic [SW-1:0] step_thr_ff;
   logic [SW-1:0] range_thr_ff;
   logic [KW-1:0] req_strk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_thr_ff  <= mssd_pkg::STEP_THR_RST;
         range_thr_ff <= mssd_pkg::RANGE_THR_RST;
         req_strk_ff  <= mssd_pkg::REQ_STRIKES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mssd_pkg::REG_STEP_THR:    step_thr_ff  <= csr_wdata;
            mssd_pkg::REG_RANGE_THR:   range_thr_ff <= csr_wdata;
            mssd_pkg::REG_REQ_STRIKES: req_strk_ff  <= csr_wdata[KW-1:0];
            default: ;
         endcase
      end
   end

   // per-channel state
   logic [PW-1:0] pos_ff    [CHANNELS];
   logic [PW-1:0] pos_in    [CHANNELS];
   logic [FW-1:0] fill_ff   [CHANNELS];
   logic [FW-1:0] fill_in   [CHANNELS];
   logic [KW-1:0] strike_ff [CHANNELS];
   logic [KW-1:0] strike_in [CHANNELS];

   logic [CI_W-1:0] ch_idx;
   logic            ch_ok;
   logic [PW-1:0]   pos_cur;
   logic [FW-1:0]   fill_cur;
   logic [FW-1:0]   fill_nxt;
   logic            short_fill;
   logic [AW-1:0]   base_cur;

   // item registers
   logic [CI_W-1:0] cur_ch_ff;
   logic [SW-1:0]   speed_ff;
   logic [PW-1:0]   skip_ff;
   logic [FW-1:0]   nfill_ff;
   logic            bypass_ff;
   logic [AW-1:0]   base_ff;

   // scan and sort
   logic [SW-1:0]   sample_mem [CHANNELS * WINDOW];
   logic [PW-1:0]   idx_ff;
   logic [AW-1:0]   rd_addr;
   logic            rd_vld_ff;
   logic            rd_skip_ff;
   logic [SW-1:0]   rd_data_ff;
   logic [SW-1:0]   srt_ff [WINDOW];
   logic [SW-1:0]   srt_in [WINDOW];
   logic [WINDOW-1:0] le;
   logic [FW-1:0]   nsrt_ff;
   logic [SW-1:0]   min_ff;
   logic [SW-1:0]   max_ff;

   // decision
   logic [FW-1:0]   rank;
   logic [SW-1:0]   med_ff;
   logic            rng_ok_ff;
   logic [SW-1:0]   diff;
   logic            susp;
   logic [KW-1:0]   strike_old;
   logic [KW-1:0]   strike_new;
   logic            res_alarm_ff;
   logic            res_susp_ff;
   logic [KW-1:0]   res_cnt_ff;

   // output register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [mssd_pkg::RSP_W-1:0] rsp_data_ff;

   assign ch_idx     = CI_W'(req_ch);
   assign ch_ok      = 32'(req_ch) < 32'(CHANNELS);
   assign pos_cur    = pos_ff[ch_idx];
   assign fill_cur   = fill_ff[ch_idx];
   assign fill_nxt   = (fill_cur == FULL_FILL) ? fill_cur : fill_cur + FW'(1);
   assign short_fill = fill_nxt < MIN_FILLV;
   assign base_cur   = AW'(ch_idx) * AW'(WINDOW);
   assign rd_addr    = base_ff + AW'(idx_ff);

   assign strike_old = strike_ff[cur_ch_ff];
   assign diff       = (speed_ff > med_ff) ? speed_ff - med_ff : med_ff - speed_ff;
   assign susp       = !bypass_ff && (diff > step_thr_ff) && rng_ok_ff;
   assign strike_new = !susp ? '0 :
                       (strike_old == mssd_pkg::STRIKE_MAX) ? strike_old :
                       strike_old + KW'(1);
   assign rank       = (nfill_ff - FW'(1)) >> 1;

   always_comb begin
      pos_in    = pos_ff;
      fill_in   = fill_ff;
      strike_in = strike_ff;
      if (cmd.start && ch_ok) begin
         pos_in[ch_idx]  = (pos_cur == LAST_POS) ? '0 : pos_cur + PW'(1);
         fill_in[ch_idx] = fill_nxt;
         if (short_fill) begin
            strike_in[ch_idx] = '0;
         end
      end
      if (cmd.calc && !bypass_ff) begin
         strike_in[cur_ch_ff] = strike_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c]    <= '0;
            fill_ff[c]   <= '0;
            strike_ff[c] <= '0;
         end
      end else begin
         pos_ff    <= pos_in;
         fill_ff   <= fill_in;
         strike_ff <= strike_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cur_ch_ff <= ch_idx;
         speed_ff  <= req_speed;
         skip_ff   <= pos_cur;
         nfill_ff  <= fill_nxt;
         bypass_ff <= !ch_ok || short_fill;
         base_ff   <= base_cur;
      end
   end

   // sample memory: one write at accept, one read per scan cycle
   always_ff @(posedge clock) begin
      if (cmd.start && ch_ok) begin
         sample_mem[base_cur + AW'(pos_cur)] <= req_speed;
      end
      if (cmd.read) begin
         rd_data_ff <= sample_mem[rd_addr];
         rd_skip_ff <= (idx_ff == skip_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff <= '0;
      end else if (cmd.read) begin
         idx_ff <= idx_ff + PW'(1);
      end
   end

   assign status.last_idx = (FW'(idx_ff) == nfill_ff - FW'(1));
   assign status.bypass   = bypass_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // insertion into the ascending window; le is a prefix of the held entries
   always_comb begin
      for (int k = 0; k < WINDOW; k++) begin
         le[k] = (FW'(k) < nsrt_ff) && (srt_ff[k] <= rd_data_ff);
      end
      srt_in[0] = le[0] ? srt_ff[0] : rd_data_ff;
      for (int k = 1; k < WINDOW; k++) begin
         srt_in[k] = le[k] ? srt_ff[k] : (le[k-1] ? rd_data_ff : srt_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && !rd_skip_ff) begin
         srt_ff <= srt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         nsrt_ff   <= '0;
      end else begin
         rd_vld_ff <= cmd.read;
         if (cmd.start) begin
            nsrt_ff <= '0;
         end else if (rd_vld_ff && !rd_skip_ff) begin
            nsrt_ff <= nsrt_ff + FW'(1);
         end
      end
   end

   // range covers every held sample, newest included
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         min_ff <= '1;
         max_ff <= '0;
      end else if (rd_vld_ff) begin
         if (rd_data_ff < min_ff) min_ff <= rd_data_ff;
         if (rd_data_ff > max_ff) max_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         med_ff    <= bypass_ff ? '0 : srt_ff[PW'(rank)];
         rng_ok_ff <= (max_ff - min_ff) > range_thr_ff;
      end
      if (cmd.calc) begin
         res_susp_ff  <= susp;
         res_cnt_ff   <= bypass_ff ? '0 : strike_new;
         res_alarm_ff <= !bypass_ff && (strike_new >= req_strk_ff);
      end
      if (cmd.load) begin
         rsp_data_ff <= {{mssd_pkg::RSP_PAD_W{1'b0}}, med_ff, res_cnt_ff,
                         res_susp_ff, res_alarm_ff};
      end
   end

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/median_step_spike_detector_core.sv @@
// Top level of the median step spike detector: stream ports and config port.
// Depends on mssd_pkg, mssd_ctrl and mssd_dpath.
//
// One wind-speed sample per transfer on the req_ side, tagged with its channel on
// req_tuser; exactly one result per transfer on the rsp_ side, in arrival order.
// Each channel keeps a sliding window of the latest WINDOW samples in a shared
// sample memory. Once a channel holds at least five samples, the upper median of
// its window without the newest sample and the window's max-min range are formed;
// a sample whose distance from that median exceeds step_threshold while the range
// exceeds range_threshold is a suspicious step and bumps the channel's saturating
// strike count, anything else clears it, and alarm is set while the count is at or
// above required_strikes. Short windows and channels at or above CHANNELS return an
// all-zero result (the latter touch no state). Items are handled one at a time, and
// short or out-of-range items skip the scan. The scan reads the channel's stored
// samples from the memory's single read port, one per cycle, and inserts them into
// a sorted register window. The result sits in an output register, so a stalled
// rsp_ side holds only the final step. The sample memory has no reset and needs no
// clearing pass: only written entries are ever read. The user must write registers
// on csr_ only while the block is idle; the block itself does not enforce it.
module median_step_spike_detector_core #(
   parameter int CHANNELS = 8,
   parameter int WINDOW   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // [15:0] wind_speed
   input  logic [mssd_pkg::CH_W-1:0]       req_tuser,  // [2:0] channel
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] alarm, [1] suspicious, [9:2] strike_count, [25:10] prior_median, rest 0
   output logic [mssd_pkg::RSP_W-1:0]      rsp_tdata,
   // configuration writes: 0 step_threshold, 1 range_threshold, 2 required_strikes
   input  logic                            csr_we,
   input  logic [mssd_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mssd_pkg::CSR_W-1:0]      csr_wdata
);

   mssd_pkg::cmd_type    cmd;
   mssd_pkg::status_type status;

   // sequencer: accept, scan, evaluate, hand off
   mssd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // storage, sort window, decision and output register
   mssd_dpath #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_ch     (req_tuser),
      .req_speed  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/core/mssd_checker.sv @@
// Port-level checks for the median step spike detector, bound to the top level.
// Depends on mssd_pkg and median_step_spike_detector_core_defines.svh.
`include "median_step_spike_detector_core_defines.svh"

module mssd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mssd_pkg::RSP_W-1:0] rsp_tdata
);

   `MSSD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")
   `MSSD_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp data changed while stalled")
   `MSSD_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "second transfer taken while busy")
   `MSSD_ASSERT_NOW(a_susp_counts, rsp_tvalid && rsp_tdata[mssd_pkg::SUSP_BIT], rsp_tdata[mssd_pkg::CNT_LSB +: mssd_pkg::COUNT_W] != '0, "suspicious step without strike")
   `MSSD_ASSERT_NOW(a_calm_clears, rsp_tvalid && !rsp_tdata[mssd_pkg::SUSP_BIT], rsp_tdata[mssd_pkg::CNT_LSB +: mssd_pkg::COUNT_W] == '0, "strike count kept on calm step")

endmodule

bind median_step_spike_detector_core mssd_checker u_mssd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
